/* hdl/gaussian_blur_row_filter_macros.svh */
// assertion macros for the row blur filter
`ifndef GAUSSIAN_BLUR_ROW_FILTER_MACROS_SVH
`define GAUSSIAN_BLUR_ROW_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GBR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gbr: same-cycle check failed");

// next-cycle implication
`define GBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gbr: next-cycle check failed");

`else

`define GBR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GBR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/gbr_pkg.sv */
`default_nettype none

package gbr_pkg;

    // sizes
    localparam int MAX_RADIUS     = 6;
    localparam int WIN_DEPTH      = 2 * MAX_RADIUS + 1;
    localparam int WIN_IDX_W      = $clog2(WIN_DEPTH);
    localparam int PIX_W          = 8;
    localparam int NUM_CH         = 3;
    localparam int COEF_W         = 17;
    localparam int COEF_FRAC_BITS = 16;
    localparam int RAD_W          = 3;
    localparam int POS_W          = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 17;
    localparam int PAIR_W         = PIX_W + 1;
    localparam int PROD_W         = COEF_W + PAIR_W;
    localparam int SUM_W          = PROD_W + $clog2(MAX_RADIUS + 1);
    localparam int HALF_TAPS      = MAX_RADIUS / 2;

    localparam logic [POS_W-1:0]  POS_MAX           = {POS_W{1'b1}};
    localparam logic [RAD_W-1:0]  RADIUS_RESET      = 3'd1;
    localparam logic [COEF_W-1:0] COEF_CENTER_RESET = 17'd29614;
    localparam logic [COEF_W-1:0] COEF_DIST1_RESET  = 17'd17961;
    localparam logic [PIX_W-1:0]  ALPHA_OPAQUE      = 8'hFF;

    // register indexes of the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS,
        CFG_COEF_CENTER,
        CFG_COEF_DIST1,
        CFG_COEF_DIST2,
        CFG_COEF_DIST3,
        CFG_COEF_DIST4,
        CFG_COEF_DIST5,
        CFG_COEF_DIST6
    } t_cfg_reg;

    // channel 2 is red, 1 green, 0 blue
    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_pixel;
    typedef logic [WIN_DEPTH-1:0][NUM_CH-1:0][PIX_W-1:0] t_window;
    typedef logic [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
        logic             row_end;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic [PIX_W-1:0] alpha_out;
        logic             last_in_run;
    } t_out_item;

    // effective config: clamped radius, coefficients beyond it zeroed
    typedef struct packed {
        logic [RAD_W-1:0]       rad;
        t_coef [MAX_RADIUS:0]   coef;
    } t_cfg;

    // blur request from the window stage
    typedef struct packed {
        logic vld;
        logic last;
    } t_req;

    typedef struct packed {
        logic             flushing;
        logic [POS_W-1:0] row_pos;
    } t_seq_status;

endpackage

`default_nettype wire

/* hdl/gbr_cfg.sv */
`default_nettype none

module gbr_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gbr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gbr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output gbr_pkg::t_cfg                   o_cfg
);

    logic [gbr_pkg::RAD_W-1:0]          r_radius;
    gbr_pkg::t_coef [gbr_pkg::MAX_RADIUS:0] r_coef;
    logic [gbr_pkg::RAD_W-1:0]          rad;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= gbr_pkg::RADIUS_RESET;
            r_coef[0] <= gbr_pkg::COEF_CENTER_RESET;
            r_coef[1] <= gbr_pkg::COEF_DIST1_RESET;
            for (int d = 2; d <= gbr_pkg::MAX_RADIUS; d++) begin
                r_coef[d] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == gbr_pkg::CFG_RADIUS) begin
                r_radius <= i_cfg_data[gbr_pkg::RAD_W-1:0];
            end
            for (int d = 0; d <= gbr_pkg::MAX_RADIUS; d++) begin
                if (i_cfg_index == gbr_pkg::CFG_IDX_W'(gbr_pkg::CFG_COEF_CENTER)
                        + gbr_pkg::CFG_IDX_W'(d)) begin
                    r_coef[d] <= i_cfg_data[gbr_pkg::COEF_W-1:0];
                end
            end
        end
    end

    // clamp radius, drop weights outside it
    assign rad = (r_radius > gbr_pkg::RAD_W'(gbr_pkg::MAX_RADIUS))
               ? gbr_pkg::RAD_W'(gbr_pkg::MAX_RADIUS) : r_radius;

    always_comb begin
        o_cfg.rad = rad;
        for (int d = 0; d <= gbr_pkg::MAX_RADIUS; d++) begin
            o_cfg.coef[d] = (gbr_pkg::RAD_W'(d) <= rad) ? r_coef[d] : '0;
        end
    end

endmodule

`default_nettype wire

/* hdl/gbr_window.sv */
`default_nettype none

module gbr_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  gbr_pkg::t_in_item     i_in_item,
    input  gbr_pkg::t_cfg         i_cfg,
    input  logic                  i_take,
    output gbr_pkg::t_window      o_win,
    output gbr_pkg::t_req         o_req,
    output gbr_pkg::t_seq_status  o_status
);

    gbr_pkg::t_window            r_win;
    gbr_pkg::t_window            n_win;
    logic [gbr_pkg::POS_W-1:0]   r_pos;
    logic [gbr_pkg::RAD_W-1:0]   r_rem;
    logic [gbr_pkg::RAD_W-1:0]   r_skip;
    gbr_pkg::t_req               r_req;

    logic                        step_ok;
    logic                        accept;
    logic                        pad;
    logic [gbr_pkg::RAD_W-1:0]   rad;
    logic [gbr_pkg::RAD_W-1:0]   m;
    logic [gbr_pkg::RAD_W-1:0]   s;
    gbr_pkg::t_pixel             px;

    // the window may step once the pending request has moved on
    assign step_ok    = !r_req.vld || i_take;
    assign o_in_stall = (r_rem != '0) || !step_ok;
    assign accept     = i_in_valid && !o_in_stall;
    assign pad        = (r_rem != '0) && step_ok;

    assign rad = i_cfg.rad;
    assign px  = {i_in_item.red_in, i_in_item.green_in, i_in_item.blue_in};

    // results at row end and the padding steps before the first one
    assign m = (r_pos < gbr_pkg::POS_W'(rad)) ? r_pos[gbr_pkg::RAD_W-1:0] : rad;
    assign s = rad - m;

    // row start fills, other items shift in, padding repeats the newest pixel
    always_comb begin
        n_win = r_win;
        if (accept && (r_pos == '0)) begin
            for (int k = 0; k < gbr_pkg::WIN_DEPTH; k++) begin
                n_win[k] = px;
            end
        end else if (accept) begin
            n_win = {r_win[gbr_pkg::WIN_DEPTH-2:0], px};
        end else if (pad) begin
            n_win = {r_win[gbr_pkg::WIN_DEPTH-2:0], r_win[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    // row position and flush sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_rem  <= '0;
            r_skip <= '0;
            r_req  <= '0;
        end else if (accept) begin
            if (!i_in_item.row_end) begin
                r_req.vld  <= (r_pos >= gbr_pkg::POS_W'(rad));
                r_req.last <= 1'b1;
                r_pos      <= (r_pos == gbr_pkg::POS_MAX) ? r_pos : r_pos + 1'b1;
            end else begin
                r_req.vld  <= (s == '0);
                r_req.last <= (rad == '0);
                r_rem      <= rad;
                r_skip     <= (s == '0) ? '0 : s - 1'b1;
                r_pos      <= '0;
            end
        end else if (pad) begin
            r_req.vld  <= (r_skip == '0);
            r_req.last <= (r_rem == gbr_pkg::RAD_W'(1));
            r_rem      <= r_rem - 1'b1;
            r_skip     <= (r_skip == '0) ? '0 : r_skip - 1'b1;
        end else if (step_ok) begin
            r_req.vld <= 1'b0;
        end
    end

    assign o_win             = r_win;
    assign o_req             = r_req;
    assign o_status.flushing = (r_rem != '0);
    assign o_status.row_pos  = r_pos;

endmodule

`default_nettype wire

/* hdl/gbr_datapath.sv */
`default_nettype none

module gbr_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gbr_pkg::t_window   i_win,
    input  gbr_pkg::t_req      i_req,
    input  gbr_pkg::t_cfg      i_cfg,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gbr_pkg::t_out_item o_out_item
);

    localparam int NC = gbr_pkg::NUM_CH;
    localparam int MR = gbr_pkg::MAX_RADIUS;

    // stage valids and last flags
    logic r_tap_vld, r_prod_vld, r_part_vld, r_out_vld;
    logic r_tap_last, r_prod_last, r_part_last;
    logic rdy1, rdy2, rdy3, rdy4;

    // tap stage
    logic [NC-1:0][gbr_pkg::PIX_W-1:0]            r_ctr, n_ctr;
    logic [MR:1][NC-1:0][gbr_pkg::PAIR_W-1:0]     r_pair, n_pair;
    // product stage
    logic [NC-1:0][gbr_pkg::PROD_W-1:0]           r_pc;
    logic [MR:1][NC-1:0][gbr_pkg::PROD_W-1:0]     r_pp;
    // partial sum stage
    logic [NC-1:0][gbr_pkg::SUM_W-1:0]            r_sa, r_sb, n_sa, n_sb;
    // output stage
    gbr_pkg::t_out_item                           r_out;
    logic [NC-1:0][gbr_pkg::PIX_W-1:0]            n_chan;
    logic [NC-1:0][gbr_pkg::SUM_W-1:0]            total;

    logic [gbr_pkg::WIN_IDX_W-1:0]                ctr_idx;
    logic [MR:1][gbr_pkg::WIN_IDX_W-1:0]          lt_idx, rt_idx;

    // ready chain from the output back to the window
    assign rdy4   = !r_out_vld || !i_out_stall;
    assign rdy3   = !r_part_vld || rdy4;
    assign rdy2   = !r_prod_vld || rdy3;
    assign rdy1   = !r_tap_vld || rdy2;
    assign o_take = rdy1;

    // tap select around the center at the radius, pre-add mirrored pairs
    always_comb begin
        ctr_idx = gbr_pkg::WIN_IDX_W'(i_cfg.rad);
        for (int d = 1; d <= MR; d++) begin
            lt_idx[d] = gbr_pkg::WIN_IDX_W'(i_cfg.rad) + gbr_pkg::WIN_IDX_W'(d);
            rt_idx[d] = (gbr_pkg::RAD_W'(d) <= i_cfg.rad)
                      ? gbr_pkg::WIN_IDX_W'(i_cfg.rad) - gbr_pkg::WIN_IDX_W'(d) : '0;
        end
        for (int c = 0; c < NC; c++) begin
            n_ctr[c] = i_win[ctr_idx][c];
            for (int d = 1; d <= MR; d++) begin
                n_pair[d][c] = {1'b0, i_win[lt_idx[d]][c]} + {1'b0, i_win[rt_idx[d]][c]};
            end
        end
    end

    // partial sums: center and near pairs, far pairs
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_sa[c] = gbr_pkg::SUM_W'(r_pc[c]);
            n_sb[c] = '0;
            for (int d = 1; d <= MR; d++) begin
                if (d <= gbr_pkg::HALF_TAPS) begin
                    n_sa[c] = n_sa[c] + gbr_pkg::SUM_W'(r_pp[d][c]);
                end else begin
                    n_sb[c] = n_sb[c] + gbr_pkg::SUM_W'(r_pp[d][c]);
                end
            end
        end
    end

    // final add, truncate the fraction, saturate
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            total[c] = r_sa[c] + r_sb[c];
            if (|total[c][gbr_pkg::SUM_W-1:gbr_pkg::COEF_FRAC_BITS+gbr_pkg::PIX_W]) begin
                n_chan[c] = '1;
            end else begin
                n_chan[c] = total[c][gbr_pkg::COEF_FRAC_BITS+gbr_pkg::PIX_W-1:
                                     gbr_pkg::COEF_FRAC_BITS];
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_vld  <= 1'b0;
            r_prod_vld <= 1'b0;
            r_part_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (rdy1) begin
                r_tap_vld <= i_req.vld;
            end
            if (rdy2) begin
                r_prod_vld <= r_tap_vld;
            end
            if (rdy3) begin
                r_part_vld <= r_prod_vld;
            end
            if (rdy4) begin
                r_out_vld <= r_part_vld;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_req.vld) begin
            r_tap_last <= i_req.last;
            r_ctr      <= n_ctr;
            r_pair     <= n_pair;
        end
        if (rdy2 && r_tap_vld) begin
            r_prod_last <= r_tap_last;
            for (int c = 0; c < NC; c++) begin
                r_pc[c] <= gbr_pkg::PROD_W'(i_cfg.coef[0] * r_ctr[c]);
                for (int d = 1; d <= MR; d++) begin
                    r_pp[d][c] <= gbr_pkg::PROD_W'(i_cfg.coef[d] * r_pair[d][c]);
                end
            end
        end
        if (rdy3 && r_prod_vld) begin
            r_part_last <= r_prod_last;
            r_sa        <= n_sa;
            r_sb        <= n_sb;
        end
        if (rdy4 && r_part_vld) begin
            r_out.red_out     <= n_chan[2];
            r_out.green_out   <= n_chan[1];
            r_out.blue_out    <= n_chan[0];
            r_out.alpha_out   <= gbr_pkg::ALPHA_OPAQUE;
            r_out.last_in_run <= r_part_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

/* hdl/gaussian_blur_row_filter.sv */
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_stall    i_in_item  (gbr_pkg::t_in_item)
// out      out  o_out_valid / i_out_stall  o_out_item (gbr_pkg::t_out_item)
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one pixel per cycle while o_in_stall is low; a result passes the registers
// window, taps, products, partial sums and output register, in that order
// a row end holds the input for radius padding steps while the window is padded
// with the last pixel; one result per step once the oldest pending pixel is centered
// output stall backs up through the four stage registers before the input stalls
// synchronous active-low reset clears valids, row position and config defaults
`default_nettype none

`include "gaussian_blur_row_filter_macros.svh"

module gaussian_blur_row_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  gbr_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gbr_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gbr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gbr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    gbr_pkg::t_cfg         cfg;
    gbr_pkg::t_window      win;
    gbr_pkg::t_req         req;
    gbr_pkg::t_seq_status  seq_status;
    logic                  take;
    logic                  row_end_accept;
    logic                  alpha_ok;

    assign row_end_accept = i_in_valid && !o_in_stall && i_in_item.row_end;
    assign alpha_ok       = (o_out_item.alpha_out == gbr_pkg::ALPHA_OPAQUE);

    // configuration registers
    gbr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // pixel window and row sequencing
    gbr_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_cfg      (cfg),
        .i_take     (take),
        .o_win      (win),
        .o_req      (req),
        .o_status   (seq_status)
    );

    // weighted sum pipeline
    gbr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win       (win),
        .i_req       (req),
        .i_cfg       (cfg),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // checks
    `GBR_ASSERT_IMPL(a_no_item_while_flushing, i_clk, i_rst_n, seq_status.flushing, o_in_stall)
    `GBR_ASSERT_NEXT(a_row_restart, i_clk, i_rst_n, row_end_accept, seq_status.row_pos == '0)
    `GBR_ASSERT_IMPL(a_alpha_opaque, i_clk, i_rst_n, o_out_valid, alpha_ok)

endmodule

`default_nettype wire
